### hdl/ir_pulse_distance_frame_decoder_top_assert.svh
// Assertion macros shared by the decoder's checker.
`ifndef IR_PULSE_DISTANCE_FRAME_DECODER_TOP_ASSERT_SVH
`define IR_PULSE_DISTANCE_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while reset is held.
`define IPDFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ipdfd assertion failed");

// Next-cycle implication, sampled on aclk, off while reset is held.
`define IPDFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ipdfd assertion failed");

`endif

### hdl/ipdfd_pkg.sv
// Shared types and constants of the pulse-distance frame decoder.
package ipdfd_pkg;

    localparam int FRAME_ITEMS = 18;
    localparam int FIELD_BITS  = 8;

    localparam int TICK_W   = 15;
    localparam int POS_W    = 5;
    localparam int POS_MAX  = (1 << POS_W) - 1;
    localparam int STATUS_W = 2;

    localparam int CFG_IDX_W = 3;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_MARK  = 3'd0,
        REG_HEADER_SPACE = 3'd1,
        REG_ZERO_MARK    = 3'd2,
        REG_ZERO_SPACE   = 3'd3,
        REG_ONE_MARK     = 3'd4,
        REG_ONE_SPACE    = 3'd5,
        REG_TOLERANCE    = 3'd6,
        REG_POLARITY     = 3'd7
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_LENGTH = 2'd1,
        STATUS_HEADER = 2'd2
    } status_t;

    // One classified item as it passes from front to back.
    typedef struct packed {
        logic hdr_match;
        logic zero_match;
        logic one_match;
        logic last;
    } item_class_t;

endpackage

### hdl/ipdfd_front.sv
// Front end: configuration registers and window classification of each item.
module ipdfd_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ipdfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ipdfd_pkg::TICK_W-1:0]         cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ipdfd_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                 s_tlast,
    input  logic                                 q_full,
    output logic                                 q_push,
    output ipdfd_pkg::item_class_t               q_wdata
);

    logic [ipdfd_pkg::TICK_W-1:0] header_mark_reg;
    logic [ipdfd_pkg::TICK_W-1:0] header_space_reg;
    logic [ipdfd_pkg::TICK_W-1:0] zero_mark_reg;
    logic [ipdfd_pkg::TICK_W-1:0] zero_space_reg;
    logic [ipdfd_pkg::TICK_W-1:0] one_mark_reg;
    logic [ipdfd_pkg::TICK_W-1:0] one_space_reg;
    logic [ipdfd_pkg::TICK_W-1:0] tolerance_reg;
    logic                         polarity_reg;

    logic                         first_level;
    logic [ipdfd_pkg::TICK_W-1:0] first_duration;
    logic                         second_level;
    logic [ipdfd_pkg::TICK_W-1:0] second_duration;
    logic                         levels_ok;

    // Strict window; a margin above the target wraps the lower bound, so no match.
    function automatic logic in_window(
        input logic [ipdfd_pkg::TICK_W-1:0] raw,
        input logic [ipdfd_pkg::TICK_W-1:0] target,
        input logic [ipdfd_pkg::TICK_W-1:0] tol
    );
        logic [ipdfd_pkg::TICK_W:0] hi;
        hi = {1'b0, target} + {1'b0, tol};
        return (tol <= target) && (raw > (target - tol)) && ({1'b0, raw} < hi);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_mark_reg  <= ipdfd_pkg::TICK_W'(400);
            header_space_reg <= ipdfd_pkg::TICK_W'(6100);
            zero_mark_reg    <= ipdfd_pkg::TICK_W'(400);
            zero_space_reg   <= ipdfd_pkg::TICK_W'(2800);
            one_mark_reg     <= ipdfd_pkg::TICK_W'(400);
            one_space_reg    <= ipdfd_pkg::TICK_W'(1700);
            tolerance_reg    <= ipdfd_pkg::TICK_W'(200);
            polarity_reg     <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (ipdfd_pkg::cfg_idx_t'(cfg_index))
                ipdfd_pkg::REG_HEADER_MARK:  header_mark_reg  <= cfg_data;
                ipdfd_pkg::REG_HEADER_SPACE: header_space_reg <= cfg_data;
                ipdfd_pkg::REG_ZERO_MARK:    zero_mark_reg    <= cfg_data;
                ipdfd_pkg::REG_ZERO_SPACE:   zero_space_reg   <= cfg_data;
                ipdfd_pkg::REG_ONE_MARK:     one_mark_reg     <= cfg_data;
                ipdfd_pkg::REG_ONE_SPACE:    one_space_reg    <= cfg_data;
                ipdfd_pkg::REG_TOLERANCE:    tolerance_reg    <= cfg_data;
                ipdfd_pkg::REG_POLARITY:     polarity_reg     <= cfg_data[0];
            endcase
        end
    end

    assign first_level     = s_tdata[0];
    assign first_duration  = s_tdata[ipdfd_pkg::TICK_W:1];
    assign second_level    = s_tdata[ipdfd_pkg::TICK_W+1];
    assign second_duration = s_tdata[2*ipdfd_pkg::TICK_W+1:ipdfd_pkg::TICK_W+2];

    assign levels_ok = (first_level == polarity_reg) && (second_level != polarity_reg);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_wdata.hdr_match  = levels_ok
                          && in_window(first_duration, header_mark_reg, tolerance_reg)
                          && in_window(second_duration, header_space_reg, tolerance_reg);
        q_wdata.zero_match = levels_ok
                          && in_window(first_duration, zero_mark_reg, tolerance_reg)
                          && in_window(second_duration, zero_space_reg, tolerance_reg);
        q_wdata.one_match  = levels_ok
                          && in_window(first_duration, one_mark_reg, tolerance_reg)
                          && in_window(second_duration, one_space_reg, tolerance_reg);
        q_wdata.last       = s_tlast;
    end

endmodule

### hdl/ipdfd_queue.sv
// Short queue of classified items between front and back.
module ipdfd_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  ipdfd_pkg::item_class_t wdata,
    output logic                   full,
    input  logic                   pop,
    output logic                   rvalid,
    output ipdfd_pkg::item_class_t rdata
);

    localparam int PTR_W = (ipdfd_pkg::QUEUE_DEPTH > 1) ? $clog2(ipdfd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ipdfd_pkg::QUEUE_DEPTH + 1);

    ipdfd_pkg::item_class_t entry_reg [ipdfd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(ipdfd_pkg::QUEUE_DEPTH - 1))
            return '0;
        else
            return p + PTR_W'(1);
    endfunction

    assign full   = (count_reg == CNT_W'(ipdfd_pkg::QUEUE_DEPTH));
    assign rvalid = (count_reg != '0);
    assign rdata  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

### hdl/ipdfd_back.sv
// Back end: burst position, bit assembly and the result register.
module ipdfd_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  ipdfd_pkg::item_class_t              q_rdata,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ipdfd_pkg::OUT_DATA_W-1:0]    m_tdata
);

    logic [ipdfd_pkg::POS_W-1:0]      pos_reg;
    logic                             header_good_reg;
    logic [ipdfd_pkg::FIELD_BITS-1:0] address_reg;
    logic [ipdfd_pkg::FIELD_BITS-1:0] command_reg;
    logic                             m_valid_reg;
    logic [ipdfd_pkg::OUT_DATA_W-1:0] m_data_reg;

    logic [ipdfd_pkg::POS_W-1:0]      pos_next;
    logic                             header_good_next;
    logic [ipdfd_pkg::FIELD_BITS-1:0] address_next;
    logic [ipdfd_pkg::FIELD_BITS-1:0] command_next;
    logic                             bit_val;
    logic                             out_free;
    ipdfd_pkg::status_t               status;
    logic [ipdfd_pkg::OUT_DATA_W-1:0] result;

    assign out_free = !m_valid_reg || m_tready;
    assign q_pop    = q_valid && (!q_rdata.last || out_free);

    always_comb begin
        // zero pattern wins when both windows match
        bit_val = !q_rdata.zero_match && q_rdata.one_match;
        for (int i = 0; i < ipdfd_pkg::FIELD_BITS; i++) begin
            address_next[i] = address_reg[i]
                           || (bit_val && pos_reg == ipdfd_pkg::POS_W'(i + 1));
            command_next[i] = command_reg[i]
                           || (bit_val && pos_reg == ipdfd_pkg::POS_W'(i + 1 + ipdfd_pkg::FIELD_BITS));
        end
        header_good_next = (pos_reg == '0) ? q_rdata.hdr_match : header_good_reg;
        pos_next = (pos_reg == ipdfd_pkg::POS_W'(ipdfd_pkg::POS_MAX))
                 ? pos_reg : pos_reg + ipdfd_pkg::POS_W'(1);

        // a saturated count never equals the frame length minus one
        priority if (pos_reg != ipdfd_pkg::POS_W'(ipdfd_pkg::FRAME_ITEMS - 1)) begin
            status = ipdfd_pkg::STATUS_LENGTH;
        end else if (!header_good_next) begin
            status = ipdfd_pkg::STATUS_HEADER;
        end else begin
            status = ipdfd_pkg::STATUS_OK;
        end

        result = '0;
        result[ipdfd_pkg::STATUS_W-1:0] = status;
        if (status == ipdfd_pkg::STATUS_OK) begin
            result[ipdfd_pkg::STATUS_W +: ipdfd_pkg::FIELD_BITS] = address_next;
            result[ipdfd_pkg::STATUS_W + ipdfd_pkg::FIELD_BITS +: ipdfd_pkg::FIELD_BITS]
                = command_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            header_good_reg <= 1'b0;
            address_reg     <= '0;
            command_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                if (q_rdata.last) begin
                    pos_reg         <= '0;
                    header_good_reg <= 1'b0;
                    address_reg     <= '0;
                    command_reg     <= '0;
                    m_valid_reg     <= 1'b1;
                end else begin
                    pos_reg         <= pos_next;
                    header_good_reg <= header_good_next;
                    address_reg     <= address_next;
                    command_reg     <= command_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_rdata.last) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### hdl/ir_pulse_distance_frame_decoder_top.sv
// Top level of the IR pulse-distance frame decoder.
// Flow: a last beat is queued, then the back end pops it, registers the result and raises m_tvalid.
// Throughput: one input beat per cycle while the queue is not full; the front is combinational,
// the back retires one queued item per cycle, a last item held while a result waits on m_tready.
// Reset: aresetn is synchronous, active low; it restores register defaults, empties the
// queue, clears the burst state and drops m_tvalid.
module ir_pulse_distance_frame_decoder_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ipdfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ipdfd_pkg::TICK_W-1:0]        cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // first_level, first_duration, second_level, second_duration
    input  logic [ipdfd_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status, address, command, zero fill
    output logic [ipdfd_pkg::OUT_DATA_W-1:0]    m_tdata
);

    logic                   q_push;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_valid;
    ipdfd_pkg::item_class_t q_wdata;
    ipdfd_pkg::item_class_t q_rdata;

    ipdfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    ipdfd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rvalid  (q_valid),
        .rdata   (q_rdata)
    );

    ipdfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### hdl/ipdfd_checker.sv
// Port-level checker for the decoder top level, with its bind.
`include "ir_pulse_distance_frame_decoder_top_assert.svh"

module ipdfd_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ipdfd_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic [ipdfd_pkg::STATUS_W-1:0] status_code;

    assign status_code = m_tdata[ipdfd_pkg::STATUS_W-1:0];

    // a stalled result beat holds
    `IPDFD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // only the three defined status codes
    `IPDFD_ASSERT_NOW(a_status_code, m_tvalid, status_code <= ipdfd_pkg::STATUS_HEADER)

    // a failed burst carries neither address nor command, and the fill stays clear
    `IPDFD_ASSERT_NOW(a_fail_zero, m_tvalid && status_code != ipdfd_pkg::STATUS_OK, m_tdata[23:2] == 22'd0)

    // register writes are never back-pressured
    `IPDFD_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind ir_pulse_distance_frame_decoder_top ipdfd_checker u_ipdfd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
